// ----- rtl/core/snu_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// snu_pkg: shared types and constants of the spiking neuron update unit
// Field widths, register map, reset mode codes and the structs that pass
// between the configuration block, the update datapath and the top level.
// ----------------------------------------------------------------------------
package snu_pkg;

  localparam int IDX_W  = 8;
  localparam int POT_W  = 20;
  localparam int WGT_W  = 9;
  localparam int PRN_W  = 8;
  localparam int THR_W  = 18;
  localparam int RV_W   = 19;
  localparam int LEAK_W = 9;
  localparam int RM_W   = 2;
  localparam int FLG_W  = 4;
  localparam int MSK_W  = 8;

  localparam int APB_AW = 5;
  localparam int APB_DW = 32;

  // register map, one 32-bit word per register
  typedef enum logic [2:0] {
    REG_POS_THR    = 3'd0,
    REG_NEG_THR    = 3'd1,
    REG_LEAK       = 3'd2,
    REG_RESET_V    = 3'd3,
    REG_RESET_MODE = 3'd4,
    REG_MODE_FLAGS = 3'd5,
    REG_THR_MASK   = 3'd6
  } reg_idx_t;

  typedef enum logic [RM_W-1:0] {
    RM_LOAD = 2'd0,
    RM_SUB  = 2'd1,
    RM_KEEP = 2'd2
  } reset_mode_t;

  // bit positions within mode_flags
  localparam int FLG_LEAK_REV   = 0;
  localparam int FLG_STOCH_LEAK = 1;
  localparam int FLG_KAPPA      = 2;
  localparam int FLG_LEAK_NEG   = 3;

  localparam logic REQ_INTEGRATE  = 1'b0;
  localparam logic REQ_LEAK_FIRE  = 1'b1;

  typedef struct packed {
    logic        [THR_W-1:0]  pos_thr;
    logic        [THR_W-1:0]  neg_thr;
    logic signed [LEAK_W-1:0] leak;
    logic signed [RV_W-1:0]   reset_v;
    logic        [RM_W-1:0]   reset_mode;
    logic        [FLG_W-1:0]  flags;
    logic        [MSK_W-1:0]  thr_mask;
  } cfg_t;

  typedef struct packed {
    logic                    req_type;
    logic        [IDX_W-1:0] idx;
    logic signed [WGT_W-1:0] weight;
    logic                    stoch_w;
    logic        [PRN_W-1:0] prn;
    logic                    in_range;
  } item_t;

  typedef struct packed {
    logic signed [POT_W-1:0] potential;
    logic                    fired;
  } upd_t;

endpackage

// ----- rtl/core/snu_cfg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// snu_cfg: configuration registers
// APB-style register file holding the shared neuron parameters.
// ----------------------------------------------------------------------------
module snu_cfg
  import snu_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output cfg_t              cfg
);

  logic       wr_en;
  logic [2:0] reg_sel;

  assign wr_en   = psel & penable & pwrite;
  assign reg_sel = paddr[APB_AW-1:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (wr_en) begin
      case (reg_sel)
        REG_POS_THR:    cfg.pos_thr    <= pwdata[THR_W-1:0];
        REG_NEG_THR:    cfg.neg_thr    <= pwdata[THR_W-1:0];
        REG_LEAK:       cfg.leak       <= pwdata[LEAK_W-1:0];
        REG_RESET_V:    cfg.reset_v    <= pwdata[RV_W-1:0];
        REG_RESET_MODE: cfg.reset_mode <= pwdata[RM_W-1:0];
        REG_MODE_FLAGS: cfg.flags      <= pwdata[FLG_W-1:0];
        REG_THR_MASK:   cfg.thr_mask   <= pwdata[MSK_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_POS_THR:    prdata = APB_DW'(cfg.pos_thr);
      REG_NEG_THR:    prdata = APB_DW'(cfg.neg_thr);
      REG_LEAK:       prdata = APB_DW'(cfg.leak);
      REG_RESET_V:    prdata = APB_DW'(cfg.reset_v);
      REG_RESET_MODE: prdata = APB_DW'(cfg.reset_mode);
      REG_MODE_FLAGS: prdata = APB_DW'(cfg.flags);
      REG_THR_MASK:   prdata = APB_DW'(cfg.thr_mask);
      default:        prdata = '0;
    endcase
  end

endmodule

// ----- rtl/core/snu_store.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// snu_store: membrane potential store
// One write port, one registered read port with bypass from the write port.
// Per-entry valid bits make never-written entries read as zero after reset.
// ----------------------------------------------------------------------------
module snu_store
  import snu_pkg::*;
#(
  parameter int DEPTH = 256,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    wr_en,
  input  logic [AW-1:0]           wr_addr,
  input  logic signed [POT_W-1:0] wr_data,
  input  logic                    rd_en,
  input  logic [AW-1:0]           rd_addr,
  output logic signed [POT_W-1:0] rd_data
);

  logic signed [POT_W-1:0] mem [DEPTH];
  logic [DEPTH-1:0]        vld;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (wr_en) begin
      vld[wr_addr] <= 1'b1;
    end
  end

  // take the word being written back when it targets the same neuron
  always_ff @(posedge clk) begin
    if (rd_en) begin
      if (wr_en && (wr_addr == rd_addr)) begin
        rd_data <= wr_data;
      end else if (vld[rd_addr]) begin
        rd_data <= mem[rd_addr];
      end else begin
        rd_data <= '0;
      end
    end
  end

endmodule

// ----- rtl/core/snu_calc.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// snu_calc: neuron update datapath
// Integrate, or leak then check both thresholds, fire and reset, on one potential.
// ----------------------------------------------------------------------------
module snu_calc
  import snu_pkg::*;
(
  input  item_t                   item,
  input  logic signed [POT_W-1:0] v_old,
  input  cfg_t                    cfg,
  output upd_t                    upd
);

  localparam int EW = POT_W + 2;
  localparam logic signed [EW-1:0] PMAX = EW'((1 <<< (POT_W - 1)) - 1);
  localparam logic signed [EW-1:0] PMIN = ~PMAX;

  // value as is, or when gated its sign if its magnitude reaches the random number, else zero
  function automatic logic signed [WGT_W:0] stoch(
    input logic signed [WGT_W-1:0] v,
    input logic                    on,
    input logic [PRN_W-1:0]        rho
  );
    logic [WGT_W-1:0] mag;
    mag = v[WGT_W-1] ? WGT_W'(-v) : WGT_W'(v);
    if (!on) begin
      return (WGT_W+1)'(v);
    end else if (mag >= WGT_W'(rho)) begin
      if (v < 0) return -(WGT_W+1)'(1);
      else if (v == 0) return '0;
      else return (WGT_W+1)'(1);
    end else begin
      return '0;
    end
  endfunction

  function automatic logic signed [POT_W-1:0] sat(input logic signed [EW-1:0] v);
    if (v > PMAX) return PMAX[POT_W-1:0];
    else if (v < PMIN) return PMIN[POT_W-1:0];
    else return v[POT_W-1:0];
  endfunction

  logic signed [EW-1:0]    v_ext;
  logic signed [WGT_W:0]   w_eff;
  logic signed [WGT_W:0]   lk;
  logic                    om_neg;
  logic                    om_zero;
  logic signed [EW-1:0]    leak_add;
  logic signed [POT_W-1:0] v1;
  logic signed [EW-1:0]    v1e;
  logic signed [EW-1:0]    eta_s;
  logic signed [EW-1:0]    beta_s;
  logic signed [EW-1:0]    thr;
  logic                    fire;
  logic signed [EW-1:0]    res;

  always_comb begin
    v_ext = EW'(v_old);
    w_eff = stoch(item.weight, item.stoch_w, item.prn);
    lk    = stoch(cfg.leak, cfg.flags[FLG_STOCH_LEAK], item.prn);

    if (cfg.flags[FLG_LEAK_REV]) begin
      om_neg  = v_old < 0;
      om_zero = v_old == 0;
    end else begin
      om_neg  = cfg.flags[FLG_LEAK_NEG];
      om_zero = 1'b0;
    end

    if (om_zero) leak_add = '0;
    else if (om_neg) leak_add = -EW'(lk);
    else leak_add = EW'(lk);

    v1     = sat(v_ext + leak_add);
    v1e    = EW'(v1);
    eta_s  = EW'(item.prn & cfg.thr_mask);
    beta_s = EW'(cfg.neg_thr);
    thr    = EW'(cfg.pos_thr);
    thr    = thr + eta_s;
    fire   = v1e >= thr;

    res = v1e;
    if (fire) begin
      case (cfg.reset_mode)
        RM_LOAD: res = EW'(cfg.reset_v);
        RM_SUB:  res = v1e - thr;
        default: ;
      endcase
    end else if (cfg.flags[FLG_KAPPA]) begin
      if (v1e < -beta_s) res = -beta_s;
    end else if (v1e < -(beta_s + eta_s)) begin
      case (cfg.reset_mode)
        RM_LOAD: res = -EW'(cfg.reset_v);
        RM_SUB:  res = v1e + beta_s + eta_s;
        default: ;
      endcase
    end

    if (item.req_type == REQ_INTEGRATE) begin
      upd.potential = sat(v_ext + EW'(w_eff));
      upd.fired     = 1'b0;
    end else begin
      upd.potential = sat(res);
      upd.fired     = fire;
    end
  end

endmodule

// ----- rtl/core/spiking_neuron_update_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spiking_neuron_update_unit: leaky integrate-and-fire neuron array
// Throughput: one word per cycle while the result channel is not stalled,
//   set by the single read port of the potential store, fed by a bypass
//   from the write-back of the word ahead.
// Reset: clears the registers, the pipeline and the store's valid bits, so
//   every potential reads as zero until it is first updated.
// ----------------------------------------------------------------------------
module spiking_neuron_update_unit
  import snu_pkg::*;
#(
  parameter int NEURONS = 256
) (
  input  logic                    clk,
  input  logic                    rst,
  // request channel
  input  logic                    req_valid,
  output logic                    req_stall,
  input  logic                    req_type,
  input  logic [IDX_W-1:0]        neuron_index,
  input  logic signed [WGT_W-1:0] weight,
  input  logic                    stochastic_weight,
  input  logic [PRN_W-1:0]        prn,
  // result channel
  output logic                    res_valid,
  input  logic                    res_stall,
  output logic [IDX_W-1:0]        neuron_out,
  output logic signed [POT_W-1:0] potential,
  output logic                    fired,
  // configuration port
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [APB_AW-1:0]       paddr,
  input  logic [APB_DW-1:0]       pwdata,
  output logic [APB_DW-1:0]       prdata,
  output logic                    pready
);

  // only 2**IDX_W neurons can be named by an item
  localparam int DEPTH = (NEURONS < (1 << IDX_W)) ? NEURONS : (1 << IDX_W);
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  cfg_t                    cfg;
  item_t                   s1_item;
  logic                    s1_valid;
  logic                    s1_go;
  logic                    accept;
  logic                    wr_en;
  logic signed [POT_W-1:0] rd_data;
  upd_t                    upd;

  assign pready    = 1'b1;
  assign s1_go     = s1_valid && (!res_valid || !res_stall);
  assign req_stall = s1_valid && !s1_go;
  assign accept    = req_valid && !req_stall;
  assign wr_en     = s1_go && s1_item.in_range;

  snu_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg     (cfg)
  );

  snu_store #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_store (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (wr_en),
    .wr_addr (s1_item.idx[AW-1:0]),
    .wr_data (upd.potential),
    .rd_en   (accept),
    .rd_addr (neuron_index[AW-1:0]),
    .rd_data (rd_data)
  );

  snu_calc u_calc (
    .item  (s1_item),
    .v_old (rd_data),
    .cfg   (cfg),
    .upd   (upd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_go) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_item.req_type <= req_type;
      s1_item.idx      <= neuron_index;
      s1_item.weight   <= weight;
      s1_item.stoch_w  <= stochastic_weight;
      s1_item.prn      <= prn;
      s1_item.in_range <= int'(neuron_index) < NEURONS;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (s1_go) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  // a neuron beyond the array leaves state alone and reports zero
  always_ff @(posedge clk) begin
    if (s1_go) begin
      neuron_out <= s1_item.idx;
      potential  <= s1_item.in_range ? upd.potential : '0;
      fired      <= s1_item.in_range & upd.fired;
    end
  end

  a_reset_empty: assert property (@(posedge clk)
    rst |=> (!res_valid && !s1_valid))
    else $error("pipeline not empty after reset");

  a_stall_busy: assert property (@(posedge clk) disable iff (rst)
    req_stall |-> s1_valid)
    else $error("request stalled with empty update stage");

  a_oor_zero: assert property (@(posedge clk) disable iff (rst)
    (s1_go && !s1_item.in_range) |=> (potential == '0 && !fired))
    else $error("out-of-range neuron gave a non-zero result");

  a_int_nofire: assert property (@(posedge clk) disable iff (rst)
    (s1_go && s1_item.req_type == REQ_INTEGRATE) |=> !fired)
    else $error("integrate word reported a spike");

endmodule

// ----- sim/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the spiking neuron update unit
// Drives request words through the valid/stall channel, keeps its own copy of
// the membrane potentials and the register set, and checks every result word
// in order against it. Runs a short directed table, then random phases over
// several register settings (both extremes included), a long receiver
// hold-off that backs the pipeline up, and a phase that rides one neuron up
// to the positive rail.
// ----------------------------------------------------------------------------
module tb;
  import snu_pkg::*;

  localparam int NEURON_CNT  = 256;
  localparam int QUIET_LIMIT = 3000;
  localparam int RAIL_WORDS  = 1150;
  localparam int HOLD_CYCLES = 300;
  localparam logic [IDX_W-1:0] RAIL_UP   = 8'hA5;
  // reset mode code left unused by the block; must behave as keep
  localparam logic [RM_W-1:0] RM_SPARE = 2'd3;

  typedef enum {SET_RANDOM, SET_FLOOR, SET_CEILING} setting_t;

  typedef struct packed {
    logic                    kind;
    logic        [IDX_W-1:0] idx;
    logic signed [WGT_W-1:0] w;
    logic                    sw;
    logic        [PRN_W-1:0] rho;
    logic                    typed;
    logic signed [POT_W-1:0] pot;
    logic                    fired;
  } stim_row_t;

  typedef struct packed {
    logic        [IDX_W-1:0] idx;
    logic signed [POT_W-1:0] pot;
    logic                    fired;
  } neuron_update_t;

  logic                    clk;
  logic                    rst;
  logic                    req_valid;
  logic                    req_stall;
  logic                    req_type;
  logic [IDX_W-1:0]        neuron_index;
  logic signed [WGT_W-1:0] weight;
  logic                    stochastic_weight;
  logic [PRN_W-1:0]        prn;
  logic                    res_valid;
  logic                    res_stall;
  logic [IDX_W-1:0]        neuron_out;
  logic signed [POT_W-1:0] potential;
  logic                    fired;
  logic                    psel;
  logic                    penable;
  logic                    pwrite;
  logic [APB_AW-1:0]       paddr;
  logic [APB_DW-1:0]       pwdata;
  logic [APB_DW-1:0]       prdata;
  logic                    pready;

  spiking_neuron_update_unit #(
    .NEURONS(NEURON_CNT)
  ) u_top (
    .clk              (clk),
    .rst              (rst),
    .req_valid        (req_valid),
    .req_stall        (req_stall),
    .req_type         (req_type),
    .neuron_index     (neuron_index),
    .weight           (weight),
    .stochastic_weight(stochastic_weight),
    .prn              (prn),
    .res_valid        (res_valid),
    .res_stall        (res_stall),
    .neuron_out       (neuron_out),
    .potential        (potential),
    .fired            (fired),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  // shadow of the block's state
  cfg_t                    cfg;
  logic signed [POT_W-1:0] membrane [NEURON_CNT];
  neuron_update_t          due_updates [$];

  int               mismatches;
  int               quiet_cycles;
  int               hold_off_len;
  bit               sender_gaps;
  bit               receiver_gaps;
  logic [IDX_W-1:0] last_idx;

  localparam int DIRECTED_N = 14;
  // weight 9'h100 is -256, 9'h155 is -171
  stim_row_t directed_rows [DIRECTED_N] = '{
    '{REQ_INTEGRATE,  8'd0,   9'sd255, 1'b0, 8'd0,   1'b1, 20'sd255,  1'b0},
    '{REQ_INTEGRATE,  8'd0,   9'h100,  1'b0, 8'd255, 1'b1, -20'sd1,   1'b0},
    '{REQ_INTEGRATE,  8'd255, 9'h100,  1'b0, 8'd170, 1'b1, -20'sd256, 1'b0},
    '{REQ_INTEGRATE,  8'd1,   9'h100,  1'b1, 8'd255, 1'b1, -20'sd1,   1'b0},
    '{REQ_INTEGRATE,  8'd1,   9'sd255, 1'b1, 8'd255, 1'b0, 20'sd0,    1'b0},
    '{REQ_INTEGRATE,  8'd1,   9'sd254, 1'b1, 8'd255, 1'b0, 20'sd0,    1'b0},
    '{REQ_INTEGRATE,  8'd2,   9'sd0,   1'b1, 8'd0,   1'b0, 20'sd0,    1'b0},
    '{REQ_LEAK_FIRE,  8'd3,   9'sd255, 1'b1, 8'd255, 1'b1, 20'sd0,    1'b1},
    '{REQ_LEAK_FIRE,  8'd0,   9'h100,  1'b0, 8'd0,   1'b0, 20'sd0,    1'b0},
    '{REQ_LEAK_FIRE,  8'd255, 9'sd0,   1'b1, 8'd85,  1'b0, 20'sd0,    1'b0},
    '{REQ_INTEGRATE,  8'd170, 9'sd170, 1'b0, 8'd85,  1'b0, 20'sd0,    1'b0},
    '{REQ_INTEGRATE,  8'd85,  9'h155,  1'b1, 8'd170, 1'b0, 20'sd0,    1'b0},
    '{REQ_LEAK_FIRE,  8'd170, 9'sd170, 1'b0, 8'd255, 1'b0, 20'sd0,    1'b0},
    '{REQ_LEAK_FIRE,  8'd85,  9'sd0,   1'b0, 8'd0,   1'b0, 20'sd0,    1'b0}
  };

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int clamp_pot(int v);
    if (v > 524287) return 524287;
    if (v < -524288) return -524288;
    return v;
  endfunction

  function automatic int sign_of(int v);
    return (v > 0) ? 1 : ((v < 0) ? -1 : 0);
  endfunction

  // value as is, or its sign when its magnitude reaches rho, else nothing
  function automatic int gate_by_prn(int v, logic on, int rho);
    if (!on) return v;
    return (((v < 0) ? -v : v) >= rho) ? sign_of(v) : 0;
  endfunction

  function automatic neuron_update_t advance_neuron(stim_row_t row);
    int v;
    int alpha;
    int beta;
    int eta;
    int omega;
    neuron_update_t upd;
    v = membrane[row.idx];
    upd.fired = 1'b0;
    if (row.kind == REQ_INTEGRATE) begin
      v = clamp_pot(v + gate_by_prn(int'(row.w), row.sw, int'(row.rho)));
    end else begin
      alpha = int'(cfg.pos_thr);
      beta  = int'(cfg.neg_thr);
      eta   = int'(row.rho & cfg.thr_mask);
      omega = cfg.flags[FLG_LEAK_REV] ? sign_of(v) : (cfg.flags[FLG_LEAK_NEG] ? -1 : 1);
      v = clamp_pot(v + omega * gate_by_prn(int'($signed(cfg.leak)),
                                            cfg.flags[FLG_STOCH_LEAK], int'(row.rho)));
      if (v >= alpha + eta) begin
        upd.fired = 1'b1;
        case (cfg.reset_mode)
          RM_LOAD: v = int'($signed(cfg.reset_v));
          RM_SUB:  v = v - (alpha + eta);
          default: ;
        endcase
      end else if (cfg.flags[FLG_KAPPA]) begin
        if (v < -beta) v = -beta;
      end else if (v < -(beta + eta)) begin
        case (cfg.reset_mode)
          RM_LOAD: v = -int'($signed(cfg.reset_v));
          RM_SUB:  v = v + beta + eta;
          default: ;
        endcase
      end
      v = clamp_pot(v);
    end
    membrane[row.idx] = POT_W'(v);
    upd.idx = row.idx;
    upd.pot = POT_W'(v);
    return upd;
  endfunction

  function automatic stim_row_t make_row(logic kind, logic [IDX_W-1:0] idx,
                                         logic signed [WGT_W-1:0] w, logic sw,
                                         logic [PRN_W-1:0] rho);
    stim_row_t row;
    row = '0;
    row.kind = kind;
    row.idx  = idx;
    row.w    = w;
    row.sw   = sw;
    row.rho  = rho;
    return row;
  endfunction

  // mostly back to back, now and then a short gap, rarely a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic flag_mismatch(input string msg);
    if (mismatches < 40) $display("mismatch at %0t ns: %s", $time, msg);
    mismatches++;
  endtask

  task automatic write_reg(input reg_idx_t r, input logic [APB_DW-1:0] value);
    @(negedge clk);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {r, 2'b00};
    pwdata  = value;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    case (r)
      REG_POS_THR:    cfg.pos_thr    = value[THR_W-1:0];
      REG_NEG_THR:    cfg.neg_thr    = value[THR_W-1:0];
      REG_LEAK:       cfg.leak       = value[LEAK_W-1:0];
      REG_RESET_V:    cfg.reset_v    = value[RV_W-1:0];
      REG_RESET_MODE: cfg.reset_mode = value[RM_W-1:0];
      REG_MODE_FLAGS: cfg.flags      = value[FLG_W-1:0];
      REG_THR_MASK:   cfg.thr_mask   = value[MSK_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  task automatic load_config(input int pos_thr, input int neg_thr, input int leak,
                             input int reset_v, input int mode, input int flags,
                             input int mask);
    write_reg(REG_POS_THR, pos_thr);
    write_reg(REG_NEG_THR, neg_thr);
    write_reg(REG_LEAK, leak);
    write_reg(REG_RESET_V, reset_v);
    write_reg(REG_RESET_MODE, mode);
    write_reg(REG_MODE_FLAGS, flags);
    write_reg(REG_THR_MASK, mask);
  endtask

  task automatic issue_word(input stim_row_t row);
    int gap;
    neuron_update_t upd;
    gap = sender_gaps ? pick_gap() : 0;
    if (gap > 0) begin
      @(negedge clk);
      req_valid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    req_type          = row.kind;
    neuron_index      = row.idx;
    weight            = row.w;
    stochastic_weight = row.sw;
    prn               = row.rho;
    req_valid         = 1'b1;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    upd = advance_neuron(row);
    if (row.typed) begin
      upd.pot   = row.pot;
      upd.fired = row.fired;
    end
    due_updates.push_back(upd);
  endtask

  task automatic random_word();
    stim_row_t row;
    int r;
    row = '0;
    r = $urandom_range(0, 99);
    if (r < 30) row.idx = last_idx;
    else if (r < 70) row.idx = IDX_W'($urandom_range(0, 7));
    else row.idx = IDX_W'($urandom_range(0, 255));
    row.kind = 1'($urandom_range(0, 1));
    r = $urandom_range(0, 99);
    if (r < 15) row.w = 9'sd255;
    else if (r < 30) row.w = 9'h100;
    else row.w = WGT_W'($urandom_range(0, 511));
    row.sw = 1'($urandom_range(0, 1));
    r = $urandom_range(0, 99);
    if (r < 10) row.rho = 8'd0;
    else if (r < 20) row.rho = 8'd255;
    else row.rho = PRN_W'($urandom_range(0, 255));
    last_idx = row.idx;
    issue_word(row);
  endtask

  // drop valid and wait for every outstanding result word
  task automatic drain();
    @(negedge clk);
    req_valid = 1'b0;
    while (due_updates.size() != 0) @(posedge clk);
  endtask

  task automatic run_phase(input setting_t s, input int n, input bit s_gap,
                           input bit r_gap, input int hold);
    case (s)
      SET_FLOOR:   load_config(0, 0, -256, -262144, RM_SUB, 0, 0);
      SET_CEILING: load_config(262143, 262143, 255, 262143, RM_SPARE,
                               (1 << FLG_W) - 1, 255);
      default:     load_config($urandom_range(0, 1023), $urandom_range(0, 1023),
                               int'($urandom_range(0, 511)) - 256,
                               int'($urandom_range(0, 524287)) - 262144,
                               $urandom_range(0, 3), $urandom_range(0, 15),
                               $urandom_range(0, 255));
    endcase
    sender_gaps   = s_gap;
    receiver_gaps = r_gap;
    hold_off_len  = hold;
    repeat (n) random_word();
    drain();
  endtask

  // Park one neuron at +262144, then push it outwards until it sits on the
  // positive rail.
  task automatic run_rails();
    int rail_n;
    stim_row_t row;
    load_config(0, 0, 0, -262144, RM_LOAD, 0, 0);
    sender_gaps   = 1'b1;
    receiver_gaps = 1'b1;
    // with a zero threshold each leak-fire word flips between +R and -R
    row = make_row(REQ_LEAK_FIRE, RAIL_UP, 9'sd0, 1'b0, 8'd0);
    issue_word(row);
    if (membrane[RAIL_UP] < 0) issue_word(row);
    drain();
    load_config(262143, 262143, 255, 0, RM_KEEP, 1 << FLG_LEAK_REV, 255);
    rail_n = 0;
    for (int i = 0; i < RAIL_WORDS; i++) begin
      if (i % 16 == 15) begin
        random_word();
      end else begin
        row = make_row(rail_n[0] ? REQ_LEAK_FIRE : REQ_INTEGRATE,
                       RAIL_UP, 9'sd255, 1'b0,
                       PRN_W'($urandom_range(0, 255)));
        rail_n++;
        issue_word(row);
      end
    end
    drain();
  endtask

  // result side: random stalls, plus one long hold-off on request
  initial begin : receiver
    int stall_left;
    stall_left = 0;
    res_stall  = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_len > 0) begin
        stall_left   = hold_off_len;
        hold_off_len = 0;
      end else if (stall_left == 0 && receiver_gaps) begin
        stall_left = pick_gap();
      end
      if (stall_left > 0) begin
        res_stall = 1'b1;
        stall_left--;
      end else begin
        res_stall = 1'b0;
      end
    end
  end

  always @(posedge clk) begin : check_updates
    neuron_update_t want;
    if (!rst && res_valid && !res_stall) begin
      if (due_updates.size() == 0) begin
        flag_mismatch($sformatf("unexpected word for neuron %0d", neuron_out));
      end else begin
        want = due_updates.pop_front();
        if (neuron_out !== want.idx)
          flag_mismatch($sformatf("neuron_out %0d, want %0d", neuron_out, want.idx));
        if (potential !== want.pot)
          flag_mismatch($sformatf("neuron %0d potential %0d, want %0d",
                                  want.idx, potential, want.pot));
        if (fired !== want.fired)
          flag_mismatch($sformatf("neuron %0d fired %0b, want %0b",
                                  want.idx, fired, want.fired));
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (req_valid && !req_stall) || (res_valid && !res_stall)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("[spiking_neuron_update_unit] ERROR");
        $finish;
      end
    end
  end

  initial begin
    rst               = 1'b1;
    req_valid         = 1'b0;
    req_type          = REQ_INTEGRATE;
    neuron_index      = '0;
    weight            = '0;
    stochastic_weight = 1'b0;
    prn               = '0;
    psel              = 1'b0;
    penable           = 1'b0;
    pwrite            = 1'b0;
    paddr             = '0;
    pwdata            = '0;
    mismatches        = 0;
    quiet_cycles      = 0;
    hold_off_len      = 0;
    sender_gaps       = 1'b0;
    receiver_gaps     = 1'b0;
    last_idx          = '0;
    cfg               = '0;
    for (int n = 0; n < NEURON_CNT; n++) membrane[n] = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed words run on the reset register values, back to back
    for (int i = 0; i < DIRECTED_N; i++) issue_word(directed_rows[i]);
    drain();

    run_phase(SET_FLOOR,   80, 1'b1, 1'b0, 0);
    run_phase(SET_RANDOM,  80, 1'b0, 1'b1, 0);
    run_phase(SET_RANDOM,  80, 1'b1, 1'b1, 0);
    run_phase(SET_CEILING, 80, 1'b1, 1'b1, 0);
    run_phase(SET_RANDOM, 120, 1'b1, 1'b1, HOLD_CYCLES);
    run_phase(SET_RANDOM,  80, 1'b0, 1'b0, 0);
    run_rails();
    run_phase(SET_RANDOM,  40, 1'b1, 1'b1, 0);
    run_phase(SET_RANDOM,  40, 1'b1, 1'b0, 0);

    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("[spiking_neuron_update_unit] OK");
    end else begin
      $display("[spiking_neuron_update_unit] ERROR");
    end
    $finish;
  end

endmodule
